FILE: hdl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg: shared types and constants of the sorted key set
// Operation and status codes, field widths and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam int KEY_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } ctl_t;

endpackage

`default_nettype wire

FILE: hdl/sks_cell.sv
// ----------------------------------------------------------------------------
// sks_cell: one entry of the sorted key chain
// Holds one key, compares it with the key of the current transaction and
// takes its left or right neighbor's key when an insert or delete shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_cell (
  input  logic                              clk,
  input  sks_pkg::ctl_t                     ctl,
  input  logic signed [sks_pkg::KEY_W-1:0]  key_i,
  input  logic signed [sks_pkg::KEY_W-1:0]  left_key,
  input  logic signed [sks_pkg::KEY_W-1:0]  right_key,
  input  logic                              prev_below,
  input  logic                              occupied,
  output logic signed [sks_pkg::KEY_W-1:0]  key_q,
  output logic                              below,
  output logic                              match
);
  import sks_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  assign below = occupied && (key_r < key_i);
  assign match = occupied && (key_r == key_i);
  assign key_q = key_r;

  always_comb begin
    key_nxt = key_r;
    priority if (ctl.ins_en) begin
      if (!below) begin
        key_nxt = prev_below ? key_i : left_key;
      end
    end else if (ctl.del_en) begin
      if (!below) begin
        key_nxt = right_key;
      end
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/sorted_key_set.sv
// ----------------------------------------------------------------------------
// sorted_key_set: ordered set of distinct signed 32-bit keys
// A chain of CAPACITY cells keeps the keys in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one operation per transaction: in_tuser holds
//   the operation (insert, delete, search, clear) and in_tdata the key.
//   Every input transaction produces exactly one result transaction on the
//   output channel with status, found flag, position and the key count.
//   All cells compare the key in parallel and shift toward their neighbor in
//   the same cycle, so one operation completes per clock unless the output
//   stalls: the result appears in the output register on the cycle after
//   acceptance, and a new operation can be accepted in every unstalled cycle.
//   A single output register holds the result: while a result waits and the
//   receiver stalls, in_tready is low; when the receiver takes the result,
//   the next operation is accepted in the same cycle.
//   Reset empties the set and drops any pending result; the key storage
//   itself is not cleared, as entries at or above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sks_pkg::KEY_W-1:0]    in_tdata,   // [31:0] key
  input  logic [sks_pkg::OP_W-1:0]     in_tuser,   // [1:0] operation
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata   // [1:0] status, [2] found,
                                                   // [7:3] position, [12:8] count
);
  import sks_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic                   in_acc;
  op_t                    op;
  logic signed [KEY_W-1:0] key;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [15:0]            out_data_r;
  logic [15:0]            out_data_nxt;
  ctl_t                   ctl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]    below_v;
  logic [CAPACITY-1:0]    match_v;
  logic [CAPACITY-1:0]    bnd_v;
  logic [IW-1:0]          hit_pos_v [CAPACITY];
  logic [IW-1:0]          ins_pos_v [CAPACITY];
  logic [IW-1:0]          hit_pos;
  logic [IW-1:0]          ins_pos;
  logic                   present;
  logic                   full;

  status_t                res_status;
  logic                   res_found;
  logic [IW-1:0]          res_pos;
  logic [CW+4:0]          pos_ext;
  logic [CW+4:0]          cnt_ext;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign op        = op_t'(in_tuser);
  assign key       = $signed(in_tdata);
  assign full      = (count_r == CW'(CAPACITY));
  assign present   = |match_v;

  assign ctl.ins_en = in_acc && (op == OP_INSERT) && !full && !present;
  assign ctl.del_en = in_acc && (op == OP_DELETE) && present;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(g);
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;
    logic                    prev_below;

    if (g == 0) begin : g_first
      assign left_key   = key;
      assign prev_below = 1'b1;
    end else begin : g_mid
      assign left_key   = cell_key[g-1];
      assign prev_below = below_v[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    sks_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key_i      (key),
      .left_key   (left_key),
      .right_key  (right_key),
      .prev_below (prev_below),
      .occupied   (IDX < count_r),
      .key_q      (cell_key[g]),
      .below      (below_v[g]),
      .match      (match_v[g])
    );

    assign bnd_v[g]     = !below_v[g] && prev_below;
    assign hit_pos_v[g] = match_v[g] ? IW'(g) : '0;
    assign ins_pos_v[g] = bnd_v[g] ? IW'(g) : '0;
  end

  always_comb begin
    hit_pos = '0;
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pos = hit_pos | hit_pos_v[i];
      ins_pos = ins_pos | ins_pos_v[i];
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_found  = 1'b0;
    res_pos    = '0;
    count_nxt  = count_r;
    unique case (op)
      OP_INSERT: begin
        res_found = present;
        priority if (full) begin
          res_status = ST_FULL;
          res_pos    = present ? hit_pos : '0;
        end else if (present) begin
          res_status = ST_DUPLICATE;
          res_pos    = hit_pos;
        end else begin
          res_pos   = ins_pos;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (present) begin
          res_found = 1'b1;
          res_pos   = hit_pos;
          count_nxt = count_r - CW'(1);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_SEARCH: begin
        if (present) begin
          res_found = 1'b1;
          res_pos   = hit_pos;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign pos_ext = {(CW + 5 - IW)'(0), res_pos};
  assign cnt_ext = {5'd0, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, cnt_ext[CNT_W-1:0], pos_ext[POS_W-1:0], res_found, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("key count exceeds capacity");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("key matched in more than one cell");

  a_order_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bnd_v))
    else $error("cells below the key are not contiguous");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_CLEAR) |=> count_r == '0)
    else $error("clear did not empty the set");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the count by one");

endmodule

`default_nettype wire
